[src/gmdfs_pkg.sv]
`timescale 1ns / 1ps

package gmdfs_pkg;

    // Coordinate width: holds any cell inside a grid of up to 63 rows or columns
    localparam int CRD_W  = 6;
    localparam int POS_W  = 5;
    localparam int DIM_W  = 6;
    localparam int STEP_W = 10;
    localparam int PLEN_W = 10;
    localparam int CFGI_W = 3;
    localparam int CFGD_W = 6;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [CFGI_W-1:0] CFG_START_ROW = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_START_COL = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_GOAL_ROW  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_GOAL_COL  = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_GRID_ROWS = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_GRID_COLS = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TRY,
        ST_CHECK,
        ST_BACK,
        ST_POP
    } state_t;

    typedef struct packed {
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic             on_grid;
    } nbr_t;

endpackage

[src/grid_maze_dfs_path_finder_unit.sv]
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// req     | req_valid, req_ready | action, cell_row, cell_col, cell_blocked, step_index
// rsp     | rsp_valid, rsp_ready | found, path_length, direction
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Cell write and no-op: the result is valid in the cycle after the transfer. Path read:
// the path memory is read, then ST_READ registers the result. Search: ST_TRY and ST_CHECK
// probe each neighbor in the grid, ST_TRY alone skips one off it; ST_BACK, ST_POP backtrack.
// Reset clears control and configuration; the cell and path memories keep their contents.
// req_ready is low while a search or read runs and while a result waits and is not taken.

module grid_maze_dfs_path_finder_unit
    import gmdfs_pkg::*;
#(
    parameter int MAX_SIDE = 32,
    parameter int MAX_PATH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        action,
    input  logic [POS_W-1:0]  cell_row,
    input  logic [POS_W-1:0]  cell_col,
    input  logic              cell_blocked,
    input  logic [STEP_W-1:0] step_index,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              found,
    output logic [PLEN_W-1:0] path_length,
    output logic [1:0]        direction,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFGD_W-1:0] cfg_data
);

    localparam int SW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * SW;
    localparam int PW    = $clog2(MAX_PATH);
    localparam int DW    = PW + 1;
    localparam int CMP_W = (DW > STEP_W) ? DW : STEP_W;

    logic [POS_W-1:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic [DIM_W-1:0] grid_rows_reg, grid_cols_reg;

    state_t            state_reg, state_next;
    logic [CRD_W-1:0]  cur_row_reg, cur_row_next;
    logic [CRD_W-1:0]  cur_col_reg, cur_col_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [1:0]        try_dir_reg, try_dir_next;
    logic              goal_reg, goal_next;
    logic              step_ok_reg, step_ok_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              found_reg, found_next;
    logic [PLEN_W-1:0] path_length_reg, path_length_next;
    logic [1:0]        direction_reg, direction_next;

    logic              cl_mem [2**AW];
    logic              cl_we, cl_wdata, cl_rdata_reg;
    logic [AW-1:0]     cl_waddr, cl_raddr;
    logic [1:0]        st_mem [MAX_PATH];
    logic              st_we;
    logic [1:0]        st_wdata, st_rdata_reg;
    logic [PW-1:0]     st_waddr, st_raddr;

    logic [CRD_W-1:0]  used_rows, used_cols;
    logic [CRD_W-1:0]  start_row_x, start_col_x;
    logic              start_in, start_is_goal, nbr_is_goal, req_xfer;
    logic [1:0]        nbr_dir;
    logic [DW-1:0]     depth_plus, depth_minus;
    nbr_t              nbr;
    logic [AW-1:0]     nbr_addr;

    assign used_rows = (int'(grid_rows_reg) > MAX_SIDE) ? CRD_W'(MAX_SIDE) : grid_rows_reg;
    assign used_cols = (int'(grid_cols_reg) > MAX_SIDE) ? CRD_W'(MAX_SIDE) : grid_cols_reg;
    assign start_row_x   = CRD_W'(start_row_reg);
    assign start_col_x   = CRD_W'(start_col_reg);
    assign start_in      = (start_row_x < used_rows) && (start_col_x < used_cols);
    assign start_is_goal = (start_row_reg == goal_row_reg) && (start_col_reg == goal_col_reg);
    assign nbr_is_goal   = (nbr.row == CRD_W'(goal_row_reg)) && (nbr.col == CRD_W'(goal_col_reg));
    assign depth_plus    = depth_reg + 1'b1;
    assign depth_minus   = depth_reg - 1'b1;
    assign nbr_addr      = {SW'(nbr.row), SW'(nbr.col)};
    assign nbr_dir       = (state_reg == ST_POP) ? {~st_rdata_reg[1], st_rdata_reg[0]}
                                                 : try_dir_reg;

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_xfer  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign path_length = path_length_reg;
    assign direction   = direction_reg;

    gmdfs_nbr u_nbr (
        .cur_row   (cur_row_reg),
        .cur_col   (cur_col_reg),
        .dir       (nbr_dir),
        .used_rows (used_rows),
        .used_cols (used_cols),
        .nbr       (nbr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= '0;
            goal_col_reg  <= '0;
            grid_rows_reg <= DIM_W'(32);
            grid_cols_reg <= DIM_W'(32);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_ROW: start_row_reg <= cfg_data[POS_W-1:0];
                CFG_START_COL: start_col_reg <= cfg_data[POS_W-1:0];
                CFG_GOAL_ROW:  goal_row_reg  <= cfg_data[POS_W-1:0];
                CFG_GOAL_COL:  goal_col_reg  <= cfg_data[POS_W-1:0];
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            depth_reg     <= '0;
            try_dir_reg   <= DIR_NORTH;
            goal_reg      <= 1'b0;
            step_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            depth_reg     <= depth_next;
            try_dir_reg   <= try_dir_next;
            goal_reg      <= goal_next;
            step_ok_reg   <= step_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg       <= found_next;
        path_length_reg <= path_length_next;
        direction_reg   <= direction_next;
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        cl_rdata_reg <= cl_mem[cl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= st_mem[st_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        depth_next       = depth_reg;
        try_dir_next     = try_dir_reg;
        goal_next        = goal_reg;
        step_ok_next     = step_ok_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        found_next       = found_reg;
        path_length_next = path_length_reg;
        direction_next   = direction_reg;
        cl_we            = 1'b0;
        cl_waddr         = nbr_addr;
        cl_wdata         = 1'b1;
        cl_raddr         = nbr_addr;
        st_we            = 1'b0;
        st_waddr         = depth_reg[PW-1:0];
        st_wdata         = try_dir_reg;
        st_raddr         = depth_minus[PW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    found_next       = goal_reg;
                    path_length_next = goal_reg ? PLEN_W'(depth_reg) : '0;
                    direction_next   = DIR_NORTH;
                    unique case (action_t'(action))
                        ACT_WRITE:
                        begin
                            rsp_valid_next = 1'b1;
                            if ((int'(cell_row) < MAX_SIDE) && (int'(cell_col) < MAX_SIDE))
                            begin
                                cl_we    = 1'b1;
                                cl_waddr = {SW'(cell_row), SW'(cell_col)};
                                cl_wdata = cell_blocked;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            depth_next       = '0;
                            cur_row_next     = start_row_x;
                            cur_col_next     = start_col_x;
                            path_length_next = '0;
                            if (start_in)
                            begin
                                cl_we    = 1'b1;
                                cl_waddr = {SW'(start_row_x), SW'(start_col_x)};
                            end
                            if (!start_in || start_is_goal)
                            begin
                                goal_next      = start_is_goal;
                                found_next     = start_is_goal;
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                goal_next    = 1'b0;
                                try_dir_next = DIR_NORTH;
                                state_next   = ST_TRY;
                            end
                        end
                        ACT_READ:
                        begin
                            st_raddr     = PW'(step_index);
                            step_ok_next = CMP_W'(step_index) < CMP_W'(depth_reg);
                            state_next   = ST_READ;
                        end
                        ACT_NONE:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rsp_valid_next   = 1'b1;
                found_next       = goal_reg;
                path_length_next = goal_reg ? PLEN_W'(depth_reg) : '0;
                direction_next   = (goal_reg && step_ok_reg) ? st_rdata_reg : DIR_NORTH;
                state_next       = ST_IDLE;
            end
            ST_TRY:
            begin
                if (depth_reg == DW'(MAX_PATH))
                begin
                    state_next = ST_BACK;
                end
                else if (nbr.on_grid)
                begin
                    state_next = ST_CHECK;
                end
                else if (try_dir_reg == DIR_WEST)
                begin
                    state_next = ST_BACK;
                end
                else
                begin
                    try_dir_next = try_dir_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (cl_rdata_reg)
                begin
                    if (try_dir_reg == DIR_WEST)
                    begin
                        state_next = ST_BACK;
                    end
                    else
                    begin
                        try_dir_next = try_dir_reg + 1'b1;
                        state_next   = ST_TRY;
                    end
                end
                else
                begin
                    st_we        = 1'b1;
                    cl_we        = 1'b1;
                    depth_next   = depth_plus;
                    cur_row_next = nbr.row;
                    cur_col_next = nbr.col;
                    if (nbr_is_goal)
                    begin
                        goal_next        = 1'b1;
                        rsp_valid_next   = 1'b1;
                        found_next       = 1'b1;
                        path_length_next = PLEN_W'(depth_plus);
                        direction_next   = DIR_NORTH;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        try_dir_next = DIR_NORTH;
                        state_next   = ST_TRY;
                    end
                end
            end
            ST_BACK:
            begin
                if (depth_reg == '0)
                begin
                    goal_next        = 1'b0;
                    rsp_valid_next   = 1'b1;
                    found_next       = 1'b0;
                    path_length_next = '0;
                    direction_next   = DIR_NORTH;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                cur_row_next = nbr.row;
                cur_col_next = nbr.col;
                depth_next   = depth_minus;
                if (st_rdata_reg == DIR_WEST)
                begin
                    state_next = ST_BACK;
                end
                else
                begin
                    try_dir_next = st_rdata_reg + 1'b1;
                    state_next   = ST_TRY;
                end
            end
        endcase
    end

endmodule

[src/gmdfs_nbr.sv]
`timescale 1ns / 1ps

module gmdfs_nbr
    import gmdfs_pkg::*;
(
    input  logic [CRD_W-1:0] cur_row,
    input  logic [CRD_W-1:0] cur_col,
    input  logic [1:0]       dir,
    input  logic [CRD_W-1:0] used_rows,
    input  logic [CRD_W-1:0] used_cols,
    output nbr_t             nbr
);

    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    logic             no_wrap;

    always_comb
    begin
        row     = cur_row;
        col     = cur_col;
        no_wrap = 1'b1;
        unique case (dir)
            DIR_NORTH:
            begin
                row     = cur_row - 1'b1;
                no_wrap = (cur_row != '0);
            end
            DIR_EAST:
            begin
                col = cur_col + 1'b1;
            end
            DIR_SOUTH:
            begin
                row = cur_row + 1'b1;
            end
            DIR_WEST:
            begin
                col     = cur_col - 1'b1;
                no_wrap = (cur_col != '0);
            end
        endcase
        nbr.row     = row;
        nbr.col     = col;
        nbr.on_grid = no_wrap && (row < used_rows) && (col < used_cols);
    end

endmodule

[src/gmdfs_checker.sv]
`timescale 1ns / 1ps

module gmdfs_checker
    import gmdfs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [1:0]        action,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              found,
    input logic [PLEN_W-1:0] path_length,
    input logic [1:0]        direction
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found)
            && $stable(path_length) && $stable(direction))
        else $error("stalled result changed");

    a_no_len_without_path: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> path_length == '0)
        else $error("path length without a found path");

    a_no_dir_without_path: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> direction == DIR_NORTH)
        else $error("direction without a found path");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (action == ACT_WRITE || action == ACT_NONE) |=> rsp_valid)
        else $error("cell write or no-op result late");

endmodule

bind grid_maze_dfs_path_finder_unit gmdfs_checker u_gmdfs_checker (.*);

[verif/maze_path_checker.sv]
`timescale 1ns / 1ps

module maze_path_checker
    import gmdfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic [1:0]        action,
    input  logic [POS_W-1:0]  cell_row,
    input  logic [POS_W-1:0]  cell_col,
    input  logic              cell_blocked,
    input  logic [STEP_W-1:0] step_index,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic              found,
    input  logic [PLEN_W-1:0] path_length,
    input  logic [1:0]        direction,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFGD_W-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding
);

    localparam int SIDE      = 32;
    localparam int TRAIL_MAX = 1024;

    typedef struct packed {
        logic              found;
        logic [PLEN_W-1:0] length;
        logic [1:0]        dir;
    } maze_result_t;

    maze_result_t     expected_q[$];
    logic             closed_map[SIDE*SIDE];
    logic [1:0]       trail[TRAIL_MAX];
    int               trail_depth;
    logic             reached;
    logic [POS_W-1:0] start_r;
    logic [POS_W-1:0] start_c;
    logic [POS_W-1:0] goal_r;
    logic [POS_W-1:0] goal_c;
    logic [DIM_W-1:0] rows_cfg;
    logic [DIM_W-1:0] cols_cfg;
    int               err_count;

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    function automatic bit in_grid(int r, int c);
        int used_r;
        int used_c;
        used_r = (rows_cfg > SIDE) ? SIDE : int'(rows_cfg);
        used_c = (cols_cfg > SIDE) ? SIDE : int'(cols_cfg);
        return r >= 0 && c >= 0 && r < used_r && c < used_c;
    endfunction

    function automatic void step_delta(input logic [1:0] d, output int dr, output int dc);
        dr = 0;
        dc = 0;
        case (d)
            DIR_NORTH: dr = -1;
            DIR_EAST:  dc = 1;
            DIR_SOUTH: dr = 1;
            DIR_WEST:  dc = -1;
            default:   dr = 0;
        endcase
    endfunction

    // depth-first walk; closed marks stay in the map after the search
    task automatic search_maze();
        int r;
        int c;
        int dr;
        int dc;
        int d;
        bit open_found;
        trail_depth = 0;
        reached     = 1'b0;
        r = int'(start_r);
        c = int'(start_c);
        if (!in_grid(r, c))
        begin
            reached = (start_r == goal_r) && (start_c == goal_c);
            return;
        end
        closed_map[r*SIDE + c] = 1'b1;
        while (!(r == int'(goal_r) && c == int'(goal_c)))
        begin
            open_found = 1'b0;
            d = 0;
            if (trail_depth < TRAIL_MAX)
            begin
                for (int k = 0; k < 4 && !open_found; k++)
                begin
                    step_delta(2'(k), dr, dc);
                    if (in_grid(r + dr, c + dc) && !closed_map[(r + dr)*SIDE + c + dc])
                    begin
                        open_found = 1'b1;
                        d = k;
                    end
                end
            end
            if (open_found)
            begin
                trail[trail_depth] = 2'(d);
                trail_depth++;
                step_delta(2'(d), dr, dc);
                r = r + dr;
                c = c + dc;
                closed_map[r*SIDE + c] = 1'b1;
            end
            else if (trail_depth == 0)
            begin
                return;
            end
            else
            begin
                trail_depth--;
                step_delta(trail[trail_depth], dr, dc);
                r = r - dr;
                c = c - dc;
            end
        end
        reached = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        maze_result_t res;
        maze_result_t exp;
        if (!rst_n)
        begin
            start_r     = '0;
            start_c     = '0;
            goal_r      = '0;
            goal_c      = '0;
            rows_cfg    = DIM_W'(SIDE);
            cols_cfg    = DIM_W'(SIDE);
            trail_depth = 0;
            reached     = 1'b0;
            err_count   = 0;
            expected_q.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_ROW: start_r  = cfg_data[POS_W-1:0];
                    CFG_START_COL: start_c  = cfg_data[POS_W-1:0];
                    CFG_GOAL_ROW:  goal_r   = cfg_data[POS_W-1:0];
                    CFG_GOAL_COL:  goal_c   = cfg_data[POS_W-1:0];
                    CFG_GRID_ROWS: rows_cfg = cfg_data;
                    CFG_GRID_COLS: cols_cfg = cfg_data;
                    default: ;
                endcase
            end

            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report($sformatf("unexpected result found=%0d length=%0d dir=%0d",
                                     found, path_length, direction));
                end
                else
                begin
                    exp = expected_q.pop_front();
                    if (found !== exp.found)
                        report($sformatf("found %0d, want %0d", found, exp.found));
                    if (path_length !== exp.length)
                        report($sformatf("path_length %0d, want %0d", path_length, exp.length));
                    if (direction !== exp.dir)
                        report($sformatf("direction %0d, want %0d", direction, exp.dir));
                end
            end

            if (req_valid && req_ready)
            begin
                res.dir = '0;
                case (action_t'(action))
                    ACT_WRITE:  closed_map[cell_row*SIDE + cell_col] = cell_blocked;
                    ACT_SEARCH: search_maze();
                    ACT_READ:
                    begin
                        if (reached && int'(step_index) < trail_depth)
                            res.dir = trail[step_index];
                    end
                    default: ;
                endcase
                res.found  = reached;
                res.length = reached ? PLEN_W'(trail_depth) : '0;
                expected_q.push_back(res);
            end

            outstanding <= expected_q.size();
            mismatches  <= err_count;
        end
    end

endmodule

[verif/grid_maze_dfs_path_finder_unit_test.sv]
`timescale 1ns / 1ps

module grid_maze_dfs_path_finder_unit_test;
    import gmdfs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int TOTAL_ITEMS = 140;
    localparam int REGION      = 6;
    localparam logic [CFGI_W-1:0] CFG_SPARE = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        action;
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;
    logic              cell_blocked;
    logic [STEP_W-1:0] step_index;
    logic              rsp_valid;
    logic              rsp_ready;
    logic              found;
    logic [PLEN_W-1:0] path_length;
    logic [1:0]        direction;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFGD_W-1:0] cfg_data;
    int                mismatches;
    int                outstanding;
    int                burst_left;
    int                sent;
    int                cycles;

    grid_maze_dfs_path_finder_unit i_dut (.*);

    maze_path_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall stretches, plus one long hold-off to back up the block
    initial
    begin
        int taken;
        int stretch;
        int mode;
        bit held;
        rsp_ready <= 1'b0;
        taken   = 0;
        stretch = 0;
        mode    = 0;
        held    = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rsp_valid && rsp_ready)
                taken++;
            if (!held && taken >= HOLD_AT)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(1, 40);
                end
                stretch--;
                case (mode)
                    0, 1:    rsp_ready <= 1'b1;
                    2:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_req(action_t act, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                            logic blk, logic [STEP_W-1:0] step);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sent++;
        req_valid    <= 1'b1;
        action       <= act;
        cell_row     <= row;
        cell_col     <= col;
        cell_blocked <= blk;
        step_index   <= step;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic write_cell(int r, int c, bit blk);
        send_req(ACT_WRITE, POS_W'(r), POS_W'(c), blk, STEP_W'($urandom));
    endtask

    task automatic run_search();
        send_req(ACT_SEARCH, POS_W'($urandom), POS_W'($urandom), 1'($urandom),
                 STEP_W'($urandom));
    endtask

    task automatic read_step(int s);
        send_req(ACT_READ, POS_W'($urandom), POS_W'($urandom), 1'($urandom), STEP_W'(s));
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_config(int sr, int sc, int gr, int gc, int rows, int cols, bit spare);
        logic [CFGI_W-1:0] regs[7];
        logic [CFGD_W-1:0] vals[7];
        int n;
        regs = '{CFG_START_ROW, CFG_START_COL, CFG_GOAL_ROW, CFG_GOAL_COL,
                 CFG_GRID_ROWS, CFG_GRID_COLS, CFG_SPARE};
        vals = '{CFGD_W'(sr), CFGD_W'(sc), CFGD_W'(gr), CFGD_W'(gc),
                 CFGD_W'(rows), CFGD_W'(cols), CFGD_W'($urandom)};
        n = spare ? 7 : 6;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // random grids stay inside the region written at the start
    function automatic int pick_side();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 1;
        return $urandom_range(2, REGION);
    endfunction

    initial
    begin
        int rows;
        int cols;
        int sr;
        int sc;
        int gr;
        int gc;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        action       <= ACT_NONE;
        cell_row     <= '0;
        cell_col     <= '0;
        cell_blocked <= 1'b0;
        step_index   <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        burst_left = 0;
        sent       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every cell a search can reach gets a defined value first
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                write_cell(r, c, 1'b0);

        // reset config: start equals goal at the corner
        send_req(ACT_NONE, '1, '1, 1'b1, '1);
        read_step(0);
        run_search();
        read_step(5);

        // search over the open region
        drain_results();
        set_config(1, 1, 4, 5, REGION, REGION, 1'b1);
        run_search();
        read_step(0);
        read_step(1);
        read_step(1023);
        read_step(3);

        // start outside the grid in use
        drain_results();
        set_config(63, 2, 1, 1, 4, 4, 1'b0);
        run_search();
        read_step(0);

        // empty grid, start equals goal outside it
        drain_results();
        set_config(31, 2, 31, 2, 0, 0, 1'b0);
        run_search();
        read_step(0);

        // start boxed in by walls, then a short path around
        drain_results();
        set_config(0, 0, 2, 2, 3, 3, 1'b0);
        write_cell(0, 1, 1'b1);
        write_cell(1, 0, 1'b1);
        run_search();
        read_step(0);
        write_cell(1, 0, 1'b0);
        write_cell(1, 1, 1'b1);
        write_cell(2, 0, 1'b0);
        write_cell(2, 1, 1'b0);
        write_cell(2, 2, 1'b0);
        run_search();
        read_step(1);
        read_step(2);

        // row count above the maximum; a wall across row 4 keeps the search near the top
        drain_results();
        set_config(0, 0, 3, 1, 33, 2, 1'b0);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 2; c++)
                write_cell(r, c, 1'b0);
        write_cell(4, 0, 1'b1);
        write_cell(4, 1, 1'b1);
        run_search();
        read_step(0);
        read_step(3);

        while (sent < TOTAL_ITEMS)
        begin
            rows = pick_side();
            cols = pick_side();
            sr = ($urandom_range(0, 4) == 0 || rows == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, rows - 1);
            sc = ($urandom_range(0, 4) == 0 || cols == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, cols - 1);
            gr = (rows == 0) ? $urandom_range(0, 31) : $urandom_range(0, rows - 1);
            gc = (cols == 0) ? $urandom_range(0, 31) : $urandom_range(0, cols - 1);
            if ($urandom_range(0, 9) == 0)
            begin
                gr = sr;
                gc = sc;
            end
            drain_results();
            set_config(sr | ($urandom_range(0, 1) << 5), sc | ($urandom_range(0, 1) << 5),
                       gr | ($urandom_range(0, 1) << 5), gc | ($urandom_range(0, 1) << 5),
                       rows, cols, $urandom_range(0, 7) == 0);
            repeat ($urandom_range(4, 8))
                write_cell($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                           ($urandom_range(0, 3) == 0));
            write_cell(gr, gc, 1'b0);
            if ($urandom_range(0, 5) == 0)
                send_req(action_t'($urandom_range(0, 3)), POS_W'($urandom),
                         POS_W'($urandom), 1'($urandom), STEP_W'($urandom));
            run_search();
            repeat ($urandom_range(1, 3))
                read_step(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 12));
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
